// ===== design/fte_pkg.sv =====
`default_nettype none

package fte_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 65536;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int TAP_COUNT  = 4;
  localparam int TAP_AW     = $clog2(TAP_COUNT);
  localparam int MEM_DEPTH  = RING_DEPTH * TAP_COUNT;
  localparam int MEM_AW     = TAP_AW + RING_AW;

  // Field widths
  localparam int SMP_W     = 16;
  localparam int LEN_W     = 17;
  localparam int GAIN_W    = 16;
  localparam int FB_W      = 17;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Arithmetic widths
  localparam int MUL_A_W = FB_W + 1;
  localparam int PROD_W  = MUL_A_W + SMP_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int RND_W   = ACC_W - 16;
  localparam int SAT_W   = RND_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEN0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FB   = 3'd5;

  localparam logic [LEN_W-1:0] LEN_RESET = 17'd9600;

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic [RING_AW-1:0]      pos_t;
  typedef logic [MEM_AW-1:0]       mem_addr_t;

  // Clamp a programmed length to the usable ring span.
  function automatic len_t eff_len(input len_t len);
    len_t res;
    res = len;
    if (len > LEN_W'(RING_DEPTH)) begin
      res = LEN_W'(RING_DEPTH);
    end else if (len == '0) begin
      res = LEN_W'(1);
    end
    return res;
  endfunction

  // Drop 16 fraction bits, round half up.
  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ACC_W'(32768);
    return t[ACC_W-1:16];
  endfunction

  function automatic sample_t sat16(input logic signed [SAT_W-1:0] v);
    sample_t res;
    if (v > SAT_W'(32767)) begin
      res = 16'sh7FFF;
    end else if (v < -SAT_W'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = v[SMP_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/fte_ring_ram.sv =====
`default_nettype none

module fte_ring_ram
  import fte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      wr_en,
  input  wire mem_addr_t wr_addr,
  input  wire sample_t   wr_data,
  input  wire logic      rd_en,
  input  wire mem_addr_t rd_addr,
  output sample_t        rd_data
);

  sample_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/four_tap_feedback_echo.sv =====
// Per item: READ, MUL and ACC for each tap, then ECHO, FBM, SUM, WRITE for each tap
// and DONE, which loads the output register once it is free; in_stall is high outside
// IDLE. The single multiplier is shared by the four taps and the feedback term, and the
// ring RAM (one read port, one write port) takes one read and one write per tap.
// Reset: synchronous on rst_n low. Config returns to its defaults, positions go to 0, and
// per-ring fill marks make unwritten ring entries read as zero; no clearing pass is run.
`default_nettype none

module four_tap_feedback_echo
  import fte_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input item channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sample_t              in_sample_in,
  // result item channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sample_t                   out_sample_out,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_ECHO  = 4'd4;
  localparam logic [3:0] S_FBM   = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_WRITE = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Configuration registers
  len_t               len_r [TAP_COUNT];
  logic [CFG_W-1:0]   gains_r;
  logic [FB_W-1:0]    fb_r;

  // Ring bookkeeping: position and fill mark (entries below it have been written)
  pos_t               pos_r [TAP_COUNT];
  len_t               hw_r  [TAP_COUNT];

  // Sequencer and datapath
  logic [3:0]               state_r;
  logic [TAP_AW-1:0]        ring_r;
  sample_t                  x_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  sample_t                  echo_r;
  sample_t                  wr_r;
  sample_t                  y_r;
  logic                     rd_valid_r;
  logic                     out_valid_r;
  sample_t                  out_sample_r;

  // Current-ring views
  logic [GAIN_W-1:0]         gain_a [TAP_COUNT];
  len_t                      len_cur;
  pos_t                      pos_cur;
  pos_t                      pos_rd;
  len_t                      pos_inc;
  pos_t                      pos_wrap;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  sample_t                   mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  // Ring RAM port
  logic      mem_wr_en;
  mem_addr_t mem_wr_addr;
  logic      mem_rd_en;
  mem_addr_t mem_rd_addr;
  sample_t   mem_rd_data;

  // Split the packed tap gains, gain i in bits 16*i+15..16*i.
  always_comb begin
    for (int i = 0; i < TAP_COUNT; i++) begin
      gain_a[i] = gains_r[i*GAIN_W +: GAIN_W];
    end
  end

  assign len_cur = eff_len(len_r[ring_r]);
  assign pos_cur = pos_r[ring_r];
  // Restart a position that a shortened ring left behind.
  assign pos_rd  = ({1'b0, pos_cur} >= len_cur) ? '0 : pos_cur;
  assign pos_inc = {1'b0, pos_cur} + LEN_W'(1);
  assign pos_wrap = (pos_inc >= len_cur) ? '0 : pos_inc[RING_AW-1:0];

  // One multiplier: tap gain times ring entry, or feedback gain times echo.
  always_comb begin
    if (state_r == S_FBM) begin
      mul_a = {1'b0, fb_r};
      mul_b = echo_r;
    end else begin
      mul_a = MUL_A_W'({1'b0, gain_a[ring_r]});
      mul_b = rd_valid_r ? mem_rd_data : '0;
    end
  end
  assign mul_p = mul_a * mul_b;

  assign mem_rd_en   = (state_r == S_READ);
  assign mem_rd_addr = {ring_r, pos_rd};
  assign mem_wr_en   = (state_r == S_WRITE);
  assign mem_wr_addr = {ring_r, pos_cur};

  fte_ring_ram u_ring_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (wr_r),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        len_r[i] <= LEN_RESET;
      end
      gains_r <= '0;
      fb_r    <= '0;
    end else if (cfg_we) begin
      priority if (cfg_index >= REG_LEN0 && cfg_index <= REG_LEN3) begin
        len_r[cfg_index[TAP_AW-1:0]] <= cfg_data[LEN_W-1:0];
      end else if (cfg_index == REG_TAPS) begin
        gains_r <= cfg_data;
      end else if (cfg_index == REG_FB) begin
        fb_r <= cfg_data[FB_W-1:0];
      end
    end
  end

  // Sequencer: per tap read, multiply, accumulate; then echo, feedback,
  // sums, four ring writes, and hand off to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ring_r      <= '0;
      for (int i = 0; i < TAP_COUNT; i++) begin
        pos_r[i] <= '0;
        hw_r[i]  <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r     <= in_sample_in;
            acc_r   <= '0;
            ring_r  <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          pos_r[ring_r] <= pos_rd;
          rd_valid_r    <= ({1'b0, pos_rd} < hw_r[ring_r]);
          state_r       <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_r + ACC_W'(prod_r);
          if (ring_r == TAP_AW'(TAP_COUNT - 1)) begin
            ring_r  <= '0;
            state_r <= S_ECHO;
          end else begin
            ring_r  <= ring_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_ECHO: begin
          echo_r  <= sat16(SAT_W'(round_q16(acc_r)));
          state_r <= S_FBM;
        end
        S_FBM: begin
          prod_r  <= mul_p;
          state_r <= S_SUM;
        end
        S_SUM: begin
          wr_r    <= sat16(SAT_W'(x_r) + SAT_W'(round_q16(ACC_W'(prod_r))));
          y_r     <= sat16(SAT_W'(x_r) + SAT_W'(echo_r));
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          // Advance the fill mark past the entry just written.
          if (pos_inc > hw_r[ring_r]) begin
            hw_r[ring_r] <= pos_inc;
          end
          pos_r[ring_r] <= pos_wrap;
          if (ring_r == TAP_AW'(TAP_COUNT - 1)) begin
            ring_r  <= '0;
            state_r <= S_DONE;
          end else begin
            ring_r <= ring_r + 1'b1;
          end
        end
        S_DONE: begin
          // Hold here until the output register is free.
          if (!out_valid_r || !out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load the finished item when free, drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_r  <= 1'b1;
      out_sample_r <= y_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // A result appears only out of the hand-off state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside hand-off state");

  // After a ring write the fill mark covers the written entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> (hw_r[$past(ring_r)] > {1'b0, $past(pos_cur)}))
    else $error("fill mark does not cover written entry");

  // The fill mark never passes the ring depth.
  for (genvar g = 0; g < TAP_COUNT; g++) begin : g_hw_chk
    assert property (@(posedge clk) disable iff (!rst_n)
      hw_r[g] <= LEN_W'(RING_DEPTH))
      else $error("fill mark beyond ring depth");
  end

endmodule

`default_nettype wire
